[hw/rtl/tsop_pkg.sv]
// ----------------------------------------------------------------------------
// tsop_pkg
// Shared types and constants for the TCP timestamp option parser.
// ----------------------------------------------------------------------------
package tsop_pkg;

    // Option kinds and lengths
    localparam logic [7:0] KIND_EOL    = 8'd0;
    localparam logic [7:0] KIND_NOP    = 8'd1;
    localparam logic [7:0] KIND_STAMP  = 8'd8;
    localparam logic [7:0] STAMP_LEN   = 8'd10;
    localparam logic [7:0] MIN_OPT_LEN = 8'd2;

    // Header geometry
    localparam logic [3:0] FIXED_HDR_WORDS = 4'd5;
    localparam logic [5:0] MAX_OPT_BYTES   = 6'd40;

    // Timestamp capture: four bytes per word, eight bytes total
    localparam logic [2:0] CAPTURE_WORD_BYTES = 3'd4;
    localparam logic [2:0] CAPTURE_LAST       = 3'd7;

    // One input item
    typedef struct packed {
        logic       start_req;
        logic [3:0] header_words;
        logic       byte_valid;
        logic [7:0] opt_byte;
        logic       last;
    } item_t;

    // One result item
    typedef struct packed {
        logic        found;
        logic [31:0] ts_value;
        logic [31:0] ts_echo;
    } result_t;

endpackage

[hw/rtl/tsop_walker.sv]
// ----------------------------------------------------------------------------
// tsop_walker
// Option walk state and the single-step update for one option-area byte.
// ----------------------------------------------------------------------------
module tsop_walker
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  tsop_pkg::item_t  item,
    output tsop_pkg::result_t result
);

    typedef enum logic [2:0] {
        PH_KIND,
        PH_LEN,
        PH_SKIP,
        PH_CAPTURE,
        PH_DONE
    } phase_t;

    phase_t      phase_reg,         phase_next;
    logic [5:0]  bytes_left_reg,    bytes_left_next;
    logic [5:0]  skip_count_reg,    skip_count_next;
    logic        is_stamp_reg,      is_stamp_next;
    logic [2:0]  capture_index_reg, capture_index_next;
    logic [31:0] value_word_reg,    value_word_next;
    logic [31:0] echo_word_reg,     echo_word_next;
    logic        found_flag_reg,    found_flag_next;

    logic [3:0]  extra_words;
    logic [5:0]  area_bytes;
    logic [8:0]  len_limit;
    logic [7:0]  b;

    assign b = item.opt_byte;

    // Option area size: 4 * (data offset - 5), capped
    assign extra_words = (item.header_words > tsop_pkg::FIXED_HDR_WORDS)
                       ? (item.header_words - tsop_pkg::FIXED_HDR_WORDS) : 4'd0;
    assign area_bytes  = ({extra_words, 2'b00} > tsop_pkg::MAX_OPT_BYTES)
                       ? tsop_pkg::MAX_OPT_BYTES : {extra_words, 2'b00};

    always_comb
    begin
        phase_next         = phase_reg;
        bytes_left_next    = bytes_left_reg;
        skip_count_next    = skip_count_reg;
        is_stamp_next      = is_stamp_reg;
        capture_index_next = capture_index_reg;
        value_word_next    = value_word_reg;
        echo_word_next     = echo_word_reg;
        found_flag_next    = found_flag_reg;

        // Restart the walk on the first item of a header
        if (item.start_req)
        begin
            bytes_left_next    = area_bytes;
            phase_next         = PH_KIND;
            skip_count_next    = '0;
            is_stamp_next      = 1'b0;
            capture_index_next = '0;
            value_word_next    = '0;
            echo_word_next     = '0;
            found_flag_next    = 1'b0;
        end

        len_limit = {3'b000, bytes_left_next} + 9'd1;

        if (item.byte_valid)
        begin
            case (phase_next)
                PH_KIND:
                begin
                    if (bytes_left_next == 6'd0 || b == tsop_pkg::KIND_EOL)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (b == tsop_pkg::KIND_NOP)
                    begin
                        bytes_left_next = bytes_left_next - 6'd1;
                    end
                    else
                    begin
                        is_stamp_next   = (b == tsop_pkg::KIND_STAMP);
                        bytes_left_next = bytes_left_next - 6'd1;
                        phase_next      = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (bytes_left_next == 6'd0 || b < tsop_pkg::MIN_OPT_LEN
                        || {1'b0, b} > len_limit)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (is_stamp_next && b == tsop_pkg::STAMP_LEN)
                    begin
                        capture_index_next = '0;
                        phase_next         = PH_CAPTURE;
                    end
                    else
                    begin
                        // length fits in the area, so it fits in six bits
                        bytes_left_next = bytes_left_next + 6'd1 - b[5:0];
                        skip_count_next = b[5:0] - tsop_pkg::MIN_OPT_LEN[5:0];
                        phase_next      = (b == tsop_pkg::MIN_OPT_LEN) ? PH_KIND : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_count_next = skip_count_next - 6'd1;
                    if (skip_count_next == 6'd0)
                    begin
                        phase_next = PH_KIND;
                    end
                end
                PH_CAPTURE:
                begin
                    if (capture_index_next < tsop_pkg::CAPTURE_WORD_BYTES)
                    begin
                        value_word_next = {value_word_next[23:0], b};
                    end
                    else
                    begin
                        echo_word_next = {echo_word_next[23:0], b};
                    end
                    if (capture_index_next == tsop_pkg::CAPTURE_LAST)
                    begin
                        found_flag_next = 1'b1;
                        phase_next      = PH_DONE;
                    end
                    else
                    begin
                        capture_index_next = capture_index_next + 3'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Report from the state after this byte
        result.found    = found_flag_next;
        result.ts_value = found_flag_next ? value_word_next : 32'd0;
        result.ts_echo  = found_flag_next ? echo_word_next  : 32'd0;

        // Close the walk after the last item
        if (item.last)
        begin
            phase_next         = PH_DONE;
            bytes_left_next    = '0;
            skip_count_next    = '0;
            is_stamp_next      = 1'b0;
            capture_index_next = '0;
            value_word_next    = '0;
            echo_word_next     = '0;
            found_flag_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_KIND;
            bytes_left_reg    <= '0;
            skip_count_reg    <= '0;
            is_stamp_reg      <= 1'b0;
            capture_index_reg <= '0;
            value_word_reg    <= '0;
            echo_word_reg     <= '0;
            found_flag_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            bytes_left_reg    <= bytes_left_next;
            skip_count_reg    <= skip_count_next;
            is_stamp_reg      <= is_stamp_next;
            capture_index_reg <= capture_index_next;
            value_word_reg    <= value_word_next;
            echo_word_reg     <= echo_word_next;
            found_flag_reg    <= found_flag_next;
        end
    end

endmodule

[hw/rtl/tcp_timestamp_option_parser.sv]
// ----------------------------------------------------------------------------
// tcp_timestamp_option_parser
// Walks a TCP option area byte by byte and reports the timestamp option.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock cycle and keeps that rate for any
// number of headers back to back while results are taken. Each input
// transfer lands in an input register; from there the option walker steps
// over that byte with a short compare/subtract update and, on a transfer
// with tlast, the result is written to the output register, which drives
// m_axis_tvalid. The output register lets the input keep flowing while a
// result waits; only a second tlast transfer stalls behind an untaken
// result. Throughput is set by the walker's one-byte-per-cycle state
// update; there is no iterative unit and no memory.
module tcp_timestamp_option_parser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [3:0] header_words, [11:4] opt_byte, [15:12] zero
    input  logic [1:0]  s_axis_tuser,   // [0] start_req, [1] byte_valid
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] ts_value, [63:32] ts_echo
    output logic [0:0]  m_axis_tuser    // [0] found
);

    tsop_pkg::item_t   in_item_reg;
    logic              in_valid_reg;
    tsop_pkg::result_t out_result_reg;
    logic              out_valid_reg;
    tsop_pkg::result_t step_result;
    tsop_pkg::item_t   s_item;
    logic              advance;
    logic              out_load;

    // Unpack the slave-side transfer
    assign s_item.start_req    = s_axis_tuser[0];
    assign s_item.header_words = s_axis_tdata[3:0];
    assign s_item.byte_valid   = s_axis_tuser[1];
    assign s_item.opt_byte     = s_axis_tdata[11:4];
    assign s_item.last         = s_axis_tlast;

    // Step the held item unless it carries a result with nowhere to go
    assign advance  = in_valid_reg && (!in_item_reg.last || !out_valid_reg || m_axis_tready);
    assign out_load = advance && in_item_reg.last;

    assign s_axis_tready = !in_valid_reg || advance;

    // Hold the accepted transfer for one step of the walker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg <= s_item;
        end
    end

    tsop_walker u_walker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (step_result)
    );

    // Output register: load on a last item, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_result_reg <= step_result;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {out_result_reg.ts_echo, out_result_reg.ts_value};
    assign m_axis_tuser[0] = out_result_reg.found;

    // A result without a timestamp carries zero words
    a_zero_when_absent: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 64'd0))
        else $error("result without timestamp has nonzero words");

    // A stalled held item is never overwritten
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("held input item lost while stalled");

    // A pending result is never overwritten before it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(out_result_reg)))
        else $error("pending result overwritten");

    // Results come only from items that close a header
    a_load_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_item_reg.last))
        else $error("result raised without a last item");

endmodule
